@@ rtl/core/i2cm_pkg.sv @@
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

  localparam int unsigned UT_W   = 13;
  localparam int unsigned WAIT_W = 16;

  localparam logic [UT_W-1:0] UNIT_TICKS_RESET = 13'd10;

  // Request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_RELEASE = 3'd1,
    REQ_START   = 3'd2,
    REQ_STOP    = 3'd3,
    REQ_WRITE   = 3'd4
  } req_code_t;

  // Active command sequence, one-hot
  typedef enum logic [4:0] {
    CMD_IDLE    = 5'b00001,
    CMD_RELEASE = 5'b00010,
    CMD_START   = 5'b00100,
    CMD_STOP    = 5'b01000,
    CMD_WRITE   = 5'b10000
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       line_sda;
  } req_word_t;

  typedef struct packed {
    logic scl_drive;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic nack;
    logic rejected;
  } res_word_t;

endpackage

@@ rtl/core/i2cm_ifs.sv @@
// Channel interfaces: request words, result words and the config write channel.
interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;
  logic       line_sda;

  modport source (output valid, output req_type, output data_byte, output line_sda,
                  input ready);
  modport sink   (input valid, input req_type, input data_byte, input line_sda,
                  output ready);
endinterface

interface i2cm_res_if;
  logic valid;
  logic ready;
  logic scl_drive;
  logic sda_drive;
  logic busy_res;
  logic done_res;
  logic nack;
  logic rejected;

  modport source (output valid, output scl_drive, output sda_drive, output busy_res,
                  output done_res, output nack, output rejected, input ready);
  modport sink   (input valid, input scl_drive, input sda_drive, input busy_res,
                  input done_res, input nack, input rejected, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/i2cm_in_reg.sv @@
// Input register stage for request words.
module i2cm_in_reg (
  input  logic               clk,
  input  logic               rst,
  i2cm_req_if.sink           req,
  input  logic               take,
  output logic               word_valid,
  output i2cm_pkg::req_word_t word
);

  logic accept;

  // Accept when empty or when the held word moves on this cycle
  assign req.ready = !word_valid || take;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (accept) begin
      word_valid <= 1'b1;
    end else if (take) begin
      word_valid <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      word.req_type  <= req.req_type;
      word.data_byte <= req.data_byte;
      word.line_sda  <= req.line_sda;
    end
  end

endmodule

@@ rtl/core/i2cm_seq.sv @@
// Line sequencer: command state, phase/hold logic and the result register.
module i2cm_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr,
  input  logic [i2cm_pkg::UT_W-1:0]   cfg_data,
  input  logic                        word_valid,
  input  i2cm_pkg::req_word_t         word,
  output logic                        take,
  output logic                        res_valid,
  input  logic                        res_ready,
  output i2cm_pkg::res_word_t         res_word
);

  typedef struct packed {
    i2cm_pkg::cmd_t                  cmd;
    logic [2:0]                      ph;
    logic [3:0]                      bit_idx;
    logic [7:0]                      sh;
    logic [i2cm_pkg::WAIT_W-1:0]     wait_cnt;
    logic                            ack;
    logic                            scl;
    logic                            sda;
  } st_t;

  typedef struct packed {
    st_t        st;
    logic [2:0] units;
  } apply_t;

  st_t                       st;
  st_t                       st_next;
  i2cm_pkg::res_word_t       res_next;
  logic [i2cm_pkg::UT_W-1:0] unit_ticks;

  // Line action of the current phase and its hold in units (0: no such phase)
  function automatic apply_t apply_phase(st_t s_in, logic sda_in);
    apply_t a;
    a.st    = s_in;
    a.units = 3'd0;
    case (s_in.cmd)
      i2cm_pkg::CMD_RELEASE: begin
        case (s_in.ph)
          3'd0: begin a.st.sda = 1'b1; a.units = 3'd1; end
          3'd1: begin a.st.scl = 1'b1; a.units = 3'd1; end
          default: a.units = 3'd0;
        endcase
      end
      i2cm_pkg::CMD_START: begin
        case (s_in.ph)
          3'd0: begin a.st.scl = 1'b1; a.units = 3'd3; end
          3'd1: begin a.st.sda = 1'b1; a.units = 3'd3; end
          3'd2: begin a.st.sda = 1'b0; a.units = 3'd3; end
          3'd3: begin a.st.scl = 1'b0; a.units = 3'd3; end
          default: a.units = 3'd0;
        endcase
      end
      i2cm_pkg::CMD_STOP: begin
        case (s_in.ph)
          3'd0: begin a.st.sda = 1'b0; a.units = 3'd3; end
          3'd1: begin a.st.scl = 1'b1; a.units = 3'd3; end
          3'd2: begin a.st.sda = 1'b1; a.units = 3'd3; end
          default: a.units = 3'd0;
        endcase
      end
      i2cm_pkg::CMD_WRITE: begin
        // Past the third phase of a data bit: move to the next bit
        if (a.st.bit_idx < 4'd8 && a.st.ph > 3'd2) begin
          a.st.bit_idx = a.st.bit_idx + 4'd1;
          a.st.ph      = 3'd0;
        end
        if (a.st.bit_idx < 4'd8) begin
          case (a.st.ph)
            3'd0: begin a.st.sda = a.st.sh[7]; a.units = 3'd3; end
            3'd1: begin a.st.scl = 1'b1; a.units = 3'd5; end
            default: begin
              a.st.scl = 1'b0;
              a.st.sh  = {a.st.sh[6:0], 1'b0};
              a.units  = 3'd2;
            end
          endcase
        end else begin
          // Acknowledge slot
          case (a.st.ph)
            3'd0: begin a.st.sda = 1'b1; a.units = 3'd3; end
            3'd1: begin a.st.scl = 1'b1; a.units = 3'd3; end
            3'd2: begin a.st.ack = !sda_in; a.units = 3'd2; end
            3'd3: begin a.st.scl = 1'b0; a.units = 3'd5; end
            default: a.units = 3'd0;
          endcase
        end
      end
      default: a.units = 3'd0;
    endcase
    return a;
  endfunction

  // Hold in ticks: units times unit_ticks by shift and add
  function automatic logic [i2cm_pkg::WAIT_W-1:0] hold_ticks(logic [2:0] units,
                                                              logic [i2cm_pkg::UT_W-1:0] ut);
    logic [i2cm_pkg::WAIT_W-1:0] u1;
    u1 = {{(i2cm_pkg::WAIT_W-i2cm_pkg::UT_W){1'b0}}, ut};
    case (units)
      3'd1:    return u1;
      3'd2:    return u1 << 1;
      3'd3:    return u1 + (u1 << 1);
      3'd5:    return u1 + (u1 << 2);
      default: return '0;
    endcase
  endfunction

  function automatic i2cm_pkg::cmd_t req_to_cmd(logic [2:0] rt);
    case (rt)
      i2cm_pkg::REQ_RELEASE: return i2cm_pkg::CMD_RELEASE;
      i2cm_pkg::REQ_START:   return i2cm_pkg::CMD_START;
      i2cm_pkg::REQ_STOP:    return i2cm_pkg::CMD_STOP;
      i2cm_pkg::REQ_WRITE:   return i2cm_pkg::CMD_WRITE;
      default:               return i2cm_pkg::CMD_IDLE;
    endcase
  endfunction

  assign take = word_valid && (!res_valid || res_ready);

  // Next state and result for the held request word
  always_comb begin
    apply_t a;
    st_t    s;
    logic   done;
    logic   nack;
    logic   rej;
    s    = st;
    done = 1'b0;
    nack = 1'b0;
    rej  = 1'b0;
    a    = '0;
    case (word.req_type)
      i2cm_pkg::REQ_RELEASE, i2cm_pkg::REQ_START, i2cm_pkg::REQ_STOP,
      i2cm_pkg::REQ_WRITE: begin
        if (st.cmd != i2cm_pkg::CMD_IDLE) begin
          rej = 1'b1;
        end else begin
          s.cmd     = req_to_cmd(word.req_type);
          s.ph      = 3'd0;
          s.bit_idx = 4'd0;
          s.sh      = word.data_byte;
          s.ack     = 1'b0;
          a         = apply_phase(s, word.line_sda);
          s         = a.st;
          s.wait_cnt = hold_ticks(a.units, unit_ticks);
        end
      end
      i2cm_pkg::REQ_TICK: begin
        if (st.cmd != i2cm_pkg::CMD_IDLE) begin
          if (st.wait_cnt > 16'd1) begin
            s.wait_cnt = st.wait_cnt - 16'd1;
          end else begin
            s.ph = st.ph + 3'd1;
            a    = apply_phase(s, word.line_sda);
            s    = a.st;
            if (a.units == 3'd0) begin
              // Sequence ends on this tick
              nack       = (st.cmd == i2cm_pkg::CMD_WRITE) && !s.ack;
              done       = 1'b1;
              s.cmd      = i2cm_pkg::CMD_IDLE;
              s.ph       = 3'd0;
              s.bit_idx  = 4'd0;
              s.wait_cnt = '0;
            end else begin
              s.wait_cnt = hold_ticks(a.units, unit_ticks);
            end
          end
        end
      end
      default: begin
        // Unknown codes leave everything as is
      end
    endcase
    st_next            = s;
    res_next.scl_drive = s.scl;
    res_next.sda_drive = s.sda;
    res_next.busy_res  = (s.cmd != i2cm_pkg::CMD_IDLE);
    res_next.done_res  = done;
    res_next.nack      = nack;
    res_next.rejected  = rej;
  end

  // Control state, config register and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st.cmd      <= i2cm_pkg::CMD_IDLE;
      st.ph       <= 3'd0;
      st.bit_idx  <= 4'd0;
      st.sh       <= 8'd0;
      st.wait_cnt <= '0;
      st.ack      <= 1'b0;
      st.scl      <= 1'b1;
      st.sda      <= 1'b1;
      unit_ticks  <= i2cm_pkg::UNIT_TICKS_RESET;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unit_ticks <= cfg_data;
      end
      if (take) begin
        st        <= st_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_word <= res_next;
    end
  end

endmodule

@@ rtl/core/i2c_master_bit_engine.sv @@
// Top level of the I2C master bit engine: request, result and config channels.
//
// Usage:
//   req carries one word per tick or command: req_type (0 tick, 1 release,
//   2 start, 3 stop, 4 write byte), data_byte for writes, and line_sda, the
//   sampled SDA level used at the acknowledge point of a write.
//   res returns exactly one word per request word, in order: the SCL/SDA
//   drive levels after that word, busy, done (end of a sequence), nack
//   (with done after a write) and rejected (command while busy).
//   cfg writes unit_ticks, the number of tick words per delay unit; it is
//   always ready; the user alone must write it only while the engine is idle.
// Path: a request word is held in the input register, then its result word
//   is registered in the result register, from which it is valid on res.
// Throughput: one word per cycle while res.ready is high; the sequencer state
//   updates in a single pass from the input register into the result register.
// Reset: lines released high, engine idle, unit_ticks = 10, both stages empty.
// Stall: while res.ready is low the result holds; one more request is taken
//   into the input register, after which req.ready drops until res drains.
module i2c_master_bit_engine (
  input  logic       clk,
  input  logic       rst,
  i2cm_cfg_if.sink   cfg,
  i2cm_req_if.sink   req,
  i2cm_res_if.source res
);

  logic                 word_valid;
  i2cm_pkg::req_word_t  word;
  logic                 take;
  i2cm_pkg::res_word_t  res_word;
  logic                 cfg_wr;

  // Config channel never stalls
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  i2cm_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .take       (take),
    .word_valid (word_valid),
    .word       (word)
  );

  i2cm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_data   (cfg.data),
    .word_valid (word_valid),
    .word       (word),
    .take       (take),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_word   (res_word)
  );

  // Result word onto the channel
  assign res.scl_drive = res_word.scl_drive;
  assign res.sda_drive = res_word.sda_drive;
  assign res.busy_res  = res_word.busy_res;
  assign res.done_res  = res_word.done_res;
  assign res.nack      = res_word.nack;
  assign res.rejected  = res_word.rejected;

endmodule

@@ rtl/core/i2cm_checker.sv @@
// Port-level checker for the I2C master bit engine, bound to the top level.
module i2cm_checker (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input logic scl_drive,
  input logic sda_drive,
  input logic busy_res,
  input logic done_res,
  input logic nack,
  input logic rejected
);

  logic out_acc;
  logic prev_busy;

  assign out_acc = res_valid && res_ready;

  // Busy flag of the last delivered result word
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_busy <= 1'b0;
    end else if (out_acc) begin
      prev_busy <= busy_res;
    end
  end

  // A sequence can only end if the previous word showed it running
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    out_acc && done_res |-> prev_busy && !busy_res)
    else $error("done without a running sequence");

  // A rejected command leaves the running sequence untouched
  a_reject_when_busy: assert property (@(posedge clk) disable iff (rst)
    out_acc && rejected |-> prev_busy && busy_res && !done_res)
    else $error("reject while idle or with done");

  // nack is only reported together with done
  a_nack_with_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && nack |-> done_res)
    else $error("nack without done");

  // Stalled result word holds
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(scl_drive) && $stable(sda_drive)
      && $stable(busy_res) && $stable(done_res) && $stable(nack) && $stable(rejected))
    else $error("result word changed while stalled");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .scl_drive (res.scl_drive),
  .sda_drive (res.sda_drive),
  .busy_res  (res.busy_res),
  .done_res  (res.done_res),
  .nack      (res.nack),
  .rejected  (res.rejected)
);
